/* hw/rtl/cps_pkg.sv */
// Shared definitions for the clamped PID step block: defaults, register
// indexes and the width rule for the saturated product terms.
// No dependencies.
package cps_pkg;

  parameter int unsigned CPS_DATA_WIDTH = 16;

  // Product terms saturate at plus or minus two to the power of this value.
  localparam int unsigned TERM_SAT_EXP = 60;

  localparam int unsigned CPS_CFG_IDX_W = 3;

  typedef enum logic [CPS_CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_OUT_MIN    = 3'd3,
    CFG_OUT_MAX    = 3'd4
  } cfg_idx_e;

  localparam int CPS_PROP_GAIN_RST  = 4;
  localparam int CPS_INTEG_GAIN_RST = 1;
  localparam int CPS_DERIV_GAIN_RST = 1;
  localparam int CPS_OUT_MIN_RST    = 0;
  localparam int CPS_OUT_MAX_RST    = 2047;

  // Width of a saturated product term: the full product width, capped at
  // the width that holds the saturation limit.
  function automatic int unsigned cps_term_w(input int unsigned dw);
    int unsigned pw;
    pw = 2 * dw + 2;
    return (pw > TERM_SAT_EXP + 2) ? TERM_SAT_EXP + 2 : pw;
  endfunction

endpackage

/* hw/rtl/cps_mul.sv */
// First work stage: forms the error, its change and the three gain products,
// each saturated, and keeps the previous error.
// Depends on cps_pkg.
module cps_mul
  import cps_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CPS_DATA_WIDTH,
  localparam int unsigned TermW = cps_term_w(DATA_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [DATA_WIDTH-1:0] target_i,
  input  logic signed [DATA_WIDTH-1:0] measured_i,
  input  logic signed [DATA_WIDTH-1:0] prop_gain_i,
  input  logic signed [DATA_WIDTH-1:0] integ_gain_i,
  input  logic signed [DATA_WIDTH-1:0] deriv_gain_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic                         rise_o,
  output logic signed [TermW-1:0]      iterm_o,
  output logic signed [TermW-1:0]      pterm_o,
  output logic signed [TermW-1:0]      dterm_o
);

  localparam int unsigned ProdW = 2 * DATA_WIDTH + 2;
  localparam int unsigned ExtW  = (ProdW > TERM_SAT_EXP + 2) ? ProdW : TERM_SAT_EXP + 2;
  localparam logic signed [ExtW-1:0] TermMax =
    {{(ExtW - TERM_SAT_EXP - 1){1'b0}}, 1'b1, {TERM_SAT_EXP{1'b0}}};
  localparam logic signed [ExtW-1:0] TermMin = -TermMax;

  function automatic logic signed [TermW-1:0] sat_term(input logic signed [ProdW-1:0] p);
    logic signed [ExtW-1:0] x;
    logic signed [ExtW-1:0] s;
    x = ExtW'(p);
    if (x > TermMax) begin
      s = TermMax;
    end else if (x < TermMin) begin
      s = TermMin;
    end else begin
      s = x;
    end
    return TermW'(s);
  endfunction

  logic                         valid_q;
  logic signed [DATA_WIDTH:0]   prior_q;
  logic signed [DATA_WIDTH:0]   err;
  logic signed [DATA_WIDTH+1:0] delta;
  logic signed [ProdW-1:0]      i_raw;
  logic signed [ProdW-1:0]      p_raw;
  logic signed [ProdW-1:0]      d_raw;
  logic                         load;
  logic                         rise_q;
  logic signed [TermW-1:0]      iterm_q;
  logic signed [TermW-1:0]      pterm_q;
  logic signed [TermW-1:0]      dterm_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    err   = (DATA_WIDTH + 1)'(target_i) - (DATA_WIDTH + 1)'(measured_i);
    delta = (DATA_WIDTH + 2)'(err) - (DATA_WIDTH + 2)'(prior_q);
    i_raw = ProdW'(err) * ProdW'(integ_gain_i);
    p_raw = ProdW'(err) * ProdW'(prop_gain_i);
    d_raw = ProdW'(delta) * ProdW'(deriv_gain_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prior_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        prior_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rise_q  <= err > prior_q;
      iterm_q <= sat_term(i_raw);
      pterm_q <= sat_term(p_raw);
      dterm_q <= sat_term(d_raw);
    end
  end

  assign valid_o = valid_q;
  assign rise_o  = rise_q;
  assign iterm_o = iterm_q;
  assign pterm_o = pterm_q;
  assign dterm_o = dterm_q;

endmodule

/* hw/rtl/cps_integ.sv */
// Second work stage: updates and clamps the integrator, and adds the
// proportional and derivative terms.
// Depends on cps_pkg.
module cps_integ
  import cps_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CPS_DATA_WIDTH,
  localparam int unsigned TermW = cps_term_w(DATA_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         rise_i,
  input  logic signed [TermW-1:0]      iterm_i,
  input  logic signed [TermW-1:0]      pterm_i,
  input  logic signed [TermW-1:0]      dterm_i,
  input  logic signed [DATA_WIDTH-1:0] out_min_i,
  input  logic signed [DATA_WIDTH-1:0] out_max_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DATA_WIDTH-1:0] integ_o,
  output logic signed [TermW:0]        pdsum_o
);

  localparam int unsigned AccW = TermW + 1;

  logic                         valid_q;
  logic signed [DATA_WIDTH-1:0] integ_q;
  logic signed [DATA_WIDTH-1:0] integ_d;
  logic signed [TermW:0]        pdsum_q;
  logic signed [AccW-1:0]       acc;
  logic signed [AccW-1:0]       lim_lo;
  logic signed [AccW-1:0]       lim_hi;
  logic signed [AccW-1:0]       acc_lo;
  logic signed [AccW-1:0]       acc_cl;
  logic                         load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    lim_lo = AccW'(out_min_i);
    lim_hi = AccW'(out_max_i);
    if (rise_i) begin
      acc = AccW'(integ_q) + AccW'(iterm_i);
    end else begin
      acc = AccW'(integ_q) - AccW'(iterm_i);
    end
    acc_lo  = (acc < lim_lo) ? lim_lo : acc;
    acc_cl  = (acc_lo > lim_hi) ? lim_hi : acc_lo;
    integ_d = DATA_WIDTH'(acc_cl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pdsum_q <= (TermW + 1)'(pterm_i) + (TermW + 1)'(dterm_i);
    end
  end

  assign valid_o = valid_q;
  assign integ_o = integ_q;
  assign pdsum_o = pdsum_q;

endmodule

/* hw/rtl/cps_out.sv */
// Output stage: forms the full-width controller sum, clamps it and holds the
// result in the output register.
// Depends on cps_pkg.
module cps_out
  import cps_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CPS_DATA_WIDTH,
  localparam int unsigned TermW = cps_term_w(DATA_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [DATA_WIDTH-1:0] integ_i,
  input  logic signed [TermW:0]        pdsum_i,
  input  logic signed [DATA_WIDTH-1:0] out_min_i,
  input  logic signed [DATA_WIDTH-1:0] out_max_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DATA_WIDTH-1:0] drive_o
);

  localparam int unsigned SumW = TermW + 2;

  logic                         valid_q;
  logic signed [DATA_WIDTH-1:0] drive_q;
  logic signed [SumW-1:0]       sum;
  logic signed [SumW-1:0]       lim_lo;
  logic signed [SumW-1:0]       lim_hi;
  logic signed [SumW-1:0]       sum_lo;
  logic signed [SumW-1:0]       sum_cl;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    lim_lo = SumW'(out_min_i);
    lim_hi = SumW'(out_max_i);
    sum    = SumW'(pdsum_i) + SumW'(integ_i);
    sum_lo = (sum < lim_lo) ? lim_lo : sum;
    sum_cl = (sum_lo > lim_hi) ? lim_hi : sum_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      drive_q <= DATA_WIDTH'(sum_cl);
    end
  end

  assign valid_o = valid_q;
  assign drive_o = drive_q;

endmodule

/* hw/rtl/clamped_pid_step_top.sv */
// Top level of the clamped PID step block: input register, configuration
// registers and the three work stages.
// Depends on cps_pkg, cps_mul, cps_integ and cps_out.
//
// Usage:
// Each transfer on the s_axis channel carries a setpoint and a measured
// sample; each brings exactly one transfer on the m_axis channel with the
// clamped controller output, in the same order.
// Gains and clamp limits are written through the cfg port (write enable,
// register index, data) while no item is in flight; writes take effect at
// once, writes to unused indexes are ignored.
// The path has four registers: input, products, integrator and output.
// One item can be taken in every cycle while the receiver does not stall, so
// the sustained rate is one item per cycle.
// The integrator and previous error update once per item, in their stage.
// Reset clears every valid flag, the integrator and the previous error and
// loads the default gains and limits; s_axis_tready is high after reset.
// When the receiver stalls, the held result stays on m_axis and the earlier
// stages keep filling; s_axis_tready falls only once all four are full.
module clamped_pid_step_top
  import cps_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CPS_DATA_WIDTH,
  localparam int unsigned InTdataW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutTdataW = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0 up: target, measured, zero padding.
  input  logic [InTdataW-1:0]      s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from bit 0 up: drive, zero padding.
  output logic [OutTdataW-1:0]     m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CPS_CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]    cfg_data_i
);

  localparam int unsigned TermW = cps_term_w(DATA_WIDTH);

  logic                         in_valid_q;
  logic signed [DATA_WIDTH-1:0] target_q;
  logic signed [DATA_WIDTH-1:0] measured_q;

  logic signed [DATA_WIDTH-1:0] prop_gain_q;
  logic signed [DATA_WIDTH-1:0] integ_gain_q;
  logic signed [DATA_WIDTH-1:0] deriv_gain_q;
  logic signed [DATA_WIDTH-1:0] out_min_q;
  logic signed [DATA_WIDTH-1:0] out_max_q;

  logic                         mul_ready;
  logic                         mul_valid;
  logic                         mul_rise;
  logic signed [TermW-1:0]      mul_iterm;
  logic signed [TermW-1:0]      mul_pterm;
  logic signed [TermW-1:0]      mul_dterm;
  logic                         integ_ready;
  logic                         integ_valid;
  logic signed [DATA_WIDTH-1:0] integ_val;
  logic signed [TermW:0]        integ_pdsum;
  logic                         out_ready;
  logic signed [DATA_WIDTH-1:0] drive;

  assign s_axis_tready = !in_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      target_q   <= s_axis_tdata[DATA_WIDTH-1:0];
      measured_q <= s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= DATA_WIDTH'(CPS_PROP_GAIN_RST);
      integ_gain_q <= DATA_WIDTH'(CPS_INTEG_GAIN_RST);
      deriv_gain_q <= DATA_WIDTH'(CPS_DERIV_GAIN_RST);
      out_min_q    <= DATA_WIDTH'(CPS_OUT_MIN_RST);
      out_max_q    <= DATA_WIDTH'(CPS_OUT_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        CFG_INTEG_GAIN: integ_gain_q <= cfg_data_i;
        CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        CFG_OUT_MIN:    out_min_q    <= cfg_data_i;
        CFG_OUT_MAX:    out_max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cps_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .ready_o     (mul_ready),
    .target_i    (target_q),
    .measured_i  (measured_q),
    .prop_gain_i (prop_gain_q),
    .integ_gain_i(integ_gain_q),
    .deriv_gain_i(deriv_gain_q),
    .valid_o     (mul_valid),
    .ready_i     (integ_ready),
    .rise_o      (mul_rise),
    .iterm_o     (mul_iterm),
    .pterm_o     (mul_pterm),
    .dterm_o     (mul_dterm)
  );

  cps_integ #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_integ (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (integ_ready),
    .rise_i   (mul_rise),
    .iterm_i  (mul_iterm),
    .pterm_i  (mul_pterm),
    .dterm_i  (mul_dterm),
    .out_min_i(out_min_q),
    .out_max_i(out_max_q),
    .valid_o  (integ_valid),
    .ready_i  (out_ready),
    .integ_o  (integ_val),
    .pdsum_o  (integ_pdsum)
  );

  cps_out #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (integ_valid),
    .ready_o  (out_ready),
    .integ_i  (integ_val),
    .pdsum_i  (integ_pdsum),
    .out_min_i(out_min_q),
    .out_max_i(out_max_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .drive_o  (drive)
  );

  assign m_axis_tdata = OutTdataW'($unsigned(drive));

endmodule

/* hw/rtl/cps_checker.sv */
// Port-level checks for clamped_pid_step_top, attached by the bind statement
// at the end of this file.
// Depends on cps_pkg and clamped_pid_step_top.
module cps_checker
  import cps_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CPS_DATA_WIDTH,
  localparam int unsigned OutTdataW = ((DATA_WIDTH + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // A stalled result transfer keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result changed while stalled");

  // The input side only stalls when every stage is full and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked output");

  // A result transfer frees the whole chain for a new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input not ready while the output drains");

  // Leaving reset, no result is offered and the input side is open.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready && !(s_axis_tvalid && 1'b0))
    else $error("pipeline not empty after reset");

endmodule

bind clamped_pid_step_top cps_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cps_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for clamped_pid_step_top: a queue-fed stream driver,
// a stream monitor with random stalls and an in-line predictor of the PID step.
// Depends on cps_pkg and the clamped_pid_step_top RTL.
module tb
  import cps_pkg::*;
();

  localparam int unsigned DW          = CPS_DATA_WIDTH;
  localparam int unsigned IN_W        = ((2 * DW + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((DW + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LATENCY     = 4;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned RAND_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam logic [CPS_CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef struct packed {
    logic [DW-1:0] measured;
    logic [DW-1:0] target;
  } sample_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_W-1:0]          s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_W-1:0]         m_axis_tdata;
  logic                     cfg_we_i      = 1'b0;
  logic [CPS_CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [DW-1:0]            cfg_data_i    = '0;

  // Controller settings and loop state as the block should hold them.
  longint gain_p, gain_i, gain_d, lim_lo, lim_hi;
  longint prev_err, integ_sum;

  sample_t       sample_q[$];
  logic [DW-1:0] drive_exp_q[$];
  sample_t       cur_sample;

  bit          idle_on   = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned tx_gap    = 0;
  int unsigned rx_gap    = 0;
  int unsigned rx_hold   = 0;
  int unsigned n_cycles  = 0;
  int unsigned n_in      = 0;
  int unsigned n_out     = 0;
  int unsigned n_writes  = 0;
  int unsigned n_inverted = 0;
  int unsigned err_cnt   = 0;

  clamped_pid_step_top #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clip(input longint v);
    if (v < lim_lo) v = lim_lo;
    if (v > lim_hi) v = lim_hi;
    return v;
  endfunction

  function automatic logic [DW-1:0] next_drive(input logic [DW-1:0] tgt,
                                               input logic [DW-1:0] meas);
    longint err, sum;
    logic [DW-1:0] drv;
    err = longint'($signed(tgt)) - longint'($signed(meas));
    if (err > prev_err) integ_sum = clip(integ_sum + err * gain_i);
    else integ_sum = clip(integ_sum - err * gain_i);
    sum = err * gain_p + integ_sum + (err - prev_err) * gain_d;
    prev_err = err;
    drv = DW'(clip(sum));
    return drv;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [DW-1:0] rand_gain();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = {1'b1, {(DW-1){1'b0}}};
      1: v = {1'b0, {(DW-1){1'b1}}};
      2: v = '0;
      3: v = DW'($urandom);
      default: v = DW'($urandom_range(0, 64) - 32);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic queue_sample(input logic [DW-1:0] tgt, input logic [DW-1:0] meas);
    sample_t s;
    s.target   = tgt;
    s.measured = meas;
    sample_q.push_back(s);
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CPS_CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_writes++;
    case (idx)
      CFG_PROP_GAIN:  gain_p = longint'($signed(val));
      CFG_INTEG_GAIN: gain_i = longint'($signed(val));
      CFG_DERIV_GAIN: gain_d = longint'($signed(val));
      CFG_OUT_MIN:    lim_lo = longint'($signed(val));
      CFG_OUT_MAX:    lim_hi = longint'($signed(val));
      default: ;
    endcase
    if (lim_lo > lim_hi) n_inverted++;
  endtask

  // Stream driver: one transfer per handshake, random gaps between items while idle_on is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        drive_exp_q.push_back(next_drive(cur_sample.target, cur_sample.measured));
        n_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          s_axis_tdata  <= IN_W'(cur_sample);
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (drive_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, drive %0d",
                                    $signed(m_axis_tdata[DW-1:0])));
        end else if (m_axis_tdata[DW-1:0] !== drive_exp_q[0]) begin
          report_mismatch($sformatf("drive got %0d, expected %0d",
                                    $signed(m_axis_tdata[DW-1:0]),
                                    $signed(drive_exp_q[0])));
          void'(drive_exp_q.pop_front());
        end else begin
          void'(drive_exp_q.pop_front());
        end
      end
      if (!hold_done && n_out >= HOLD_AT && sample_q.size() > 20) begin
        hold_done = 1'b1;
        rx_hold   = HOLD_LEN;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", n_cycles,
               drive_exp_q.size());
      $display("clamped_pid_step_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [DW-1:0] tgt, meas, delta, lo, hi, a, b;
    logic [CPS_CFG_IDX_W-1:0] idx;
    int unsigned r;

    gain_p    = CPS_PROP_GAIN_RST;
    gain_i    = CPS_INTEG_GAIN_RST;
    gain_d    = CPS_DERIV_GAIN_RST;
    lim_lo    = CPS_OUT_MIN_RST;
    lim_hi    = CPS_OUT_MAX_RST;
    prev_err  = 0;
    integ_sum = 0;
    tgt  = '0;
    meas = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sd100, 16'sd90);
    queue_sample(16'sd100, 16'sd90);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'h8000, 16'h7fff);
    queue_sample(16'h8000, 16'h7fff);
    queue_sample(16'sd5, 16'sd10);
    queue_sample(16'hffff, 16'hffff);
    queue_sample(16'h7fff, 16'h7fff);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'sd1, 16'sd0);
    queue_sample(16'sd0, 16'sd1);
    wait_drained();

    write_reg(CFG_PROP_GAIN, 16'h7fff);
    write_reg(CFG_INTEG_GAIN, 16'h8000);
    write_reg(CFG_DERIV_GAIN, 16'h7fff);
    write_reg(CFG_OUT_MIN, 16'h8000);
    write_reg(CFG_OUT_MAX, 16'h7fff);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'h8000, 16'h7fff);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'sd0, 16'sd0);
    wait_drained();

    write_reg(CFG_PROP_GAIN, 16'h8000);
    write_reg(CFG_INTEG_GAIN, 16'h7fff);
    write_reg(CFG_DERIV_GAIN, 16'h8000);
    queue_sample(16'h8000, 16'h7fff);
    queue_sample(16'h7fff, 16'h8000);
    queue_sample(16'sd3, 16'sd3);
    wait_drained();

    write_reg(CFG_OUT_MIN, 16'sd500);
    write_reg(CFG_OUT_MAX, -16'sd500);
    queue_sample(16'sd10, 16'sd0);
    queue_sample(16'sd0, 16'sd10);
    queue_sample(16'sd0, 16'sd0);
    wait_drained();

    idx = CFG_OUT_MAX;
    do begin
      idx++;
      write_reg(idx, (idx[0]) ? 16'h8000 : 16'h7fff);
    end while (idx != CFG_IDX_TOP);
    queue_sample(16'sd20, -16'sd20);
    queue_sample(-16'sd20, 16'sd20);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p % 4 != 2);
      write_reg(CFG_PROP_GAIN, rand_gain());
      write_reg(CFG_INTEG_GAIN, rand_gain());
      write_reg(CFG_DERIV_GAIN, rand_gain());
      r = $urandom_range(0, 9);
      if (r == 0) begin
        a = DW'($urandom_range(0, 20000));
        b = DW'(-$urandom_range(0, 20000));
        lo = a;
        hi = b;
      end else if (r == 1) begin
        lo = 16'h8000;
        hi = 16'h7fff;
      end else begin
        lo = DW'(-$urandom_range(0, 20000));
        hi = DW'($urandom_range(0, 20000));
      end
      write_reg(CFG_OUT_MIN, lo);
      write_reg(CFG_OUT_MAX, hi);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          tgt   = DW'($urandom);
          delta = DW'($urandom_range(0, 64) - 32);
          meas  = tgt + delta;
        end else if (r < 8) begin
          tgt  = DW'($urandom);
          meas = DW'($urandom);
        end else if (r == 9) begin
          tgt  = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
          meas = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
        end
        queue_sample(tgt, meas);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (drive_exp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", drive_exp_q.size()));
    $display("Run covered %0d input transfers and %0d checked results over %0d cycles,",
             n_in, n_out, n_cycles);
    $display("with %0d register writes, %0d of them leaving the limits inverted.",
             n_writes, n_inverted);
    if (err_cnt == 0) begin
      $display("clamped_pid_step_top: match");
    end else begin
      $display("clamped_pid_step_top: mismatch");
    end
    $finish;
  end

endmodule
